// ===== src/recency_ranked_entry_table_defines.svh =====
// ----------------------------------------------------------------------------
// recency_ranked_entry_table_defines.svh
// Assertion macros shared by the region table RTL.
// ----------------------------------------------------------------------------
`ifndef RECENCY_RANKED_ENTRY_TABLE_DEFINES_SVH
`define RECENCY_RANKED_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRET_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rret_pkg.sv =====
// ----------------------------------------------------------------------------
// rret_pkg
// Field widths and codes of the recency-ranked region table.
// ----------------------------------------------------------------------------
package rret_pkg;

    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int PRIOR_W  = 6;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2,
        STATUS_DUP  = 2'd3
    } status_t;

endpackage

// ===== src/recency_ranked_entry_table.sv =====
// Each event runs a search sweep over all slots; an event that alters the
// table then runs a read-modify-write sweep, while a miss, duplicate, full or
// no-op goes straight to the result. One event at a time: s_ready is low until
// the result of the last one is issued. Both sweeps share the single read port
// of the slot RAM. Reset: synchronous active-low; afterwards a clearing pass
// runs with s_ready low, then the table is empty.
// ----------------------------------------------------------------------------
// recency_ranked_entry_table
// Region table keyed by address with LRU rank per slot, held in one RAM.
// ----------------------------------------------------------------------------
`include "recency_ranked_entry_table_defines.svh"

module recency_ranked_entry_table
    import rret_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [ADDR_W-1:0]   s_region_address,
    input  logic [SIZE_W-1:0]   s_limit_size,
    input  logic [SIZE_W-1:0]   s_now_size,
    input  logic [SIZE_W-1:0]   s_peak_size,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_entry_count,
    output logic [PRIOR_W-1:0]  m_prior_rank
);

    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int RANK_W      = IDX_W;
    localparam int COUNT_REG_W = $clog2(ENTRIES + 1);

    // slot word: valid | rank | address | limit | size | peak
    localparam int PEAK_LSB  = 0;
    localparam int SIZE_LSB  = SIZE_W;
    localparam int LIM_LSB   = 2 * SIZE_W;
    localparam int ADDR_LSB  = 3 * SIZE_W;
    localparam int RANK_LSB  = ADDR_LSB + ADDR_W;
    localparam int VALID_BIT = RANK_LSB + RANK_W;
    localparam int WORD_W    = VALID_BIT + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_MODIFY,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [SIZE_W-1:0]      lim_reg;
    logic [SIZE_W-1:0]      now_reg;
    logic [SIZE_W-1:0]      peak_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [RANK_W-1:0]      hit_rank_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [COUNT_REG_W-1:0] count_reg;
    status_t                res_status_reg;
    logic [RANK_W-1:0]      res_prior_reg;
    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [COUNT_W-1:0]     m_entry_count_reg;
    logic [PRIOR_W-1:0]     m_prior_rank_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WORD_W-1:0]      ram_rdata;

    logic [IDX_W-1:0]       proc_idx;
    logic                   data_ok;
    logic                   sweep_end;
    logic                   rd_slot_valid;
    logic [RANK_W-1:0]      rd_rank;
    logic [ADDR_W-1:0]      rd_addr;
    logic [WORD_W-1:0]      mod_word;

    assign proc_idx      = IDX_W'(cnt_reg - CNT_W'(1));
    assign data_ok       = (cnt_reg != '0);
    assign sweep_end     = (cnt_reg == CNT_W'(ENTRIES));
    assign rd_slot_valid = ram_rdata[VALID_BIT];
    assign rd_rank       = ram_rdata[RANK_LSB +: RANK_W];
    assign rd_addr       = ram_rdata[ADDR_LSB +: ADDR_W];

    assign ram_re    = ((state_reg == ST_SEARCH) || (state_reg == ST_MODIFY)) && !sweep_end;
    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_MODIFY) && data_ok);
    assign ram_waddr = (state_reg == ST_CLEAR) ? cnt_reg[IDX_W-1:0] : proc_idx;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : mod_word;

    always_comb begin
        mod_word = ram_rdata;
        if (func_reg == FUNC_INSERT) begin
            if (proc_idx == free_idx_reg) begin
                mod_word                       = '0;
                mod_word[VALID_BIT]            = 1'b1;
                mod_word[ADDR_LSB +: ADDR_W]   = addr_reg;
                mod_word[LIM_LSB +: SIZE_W]    = lim_reg;
            end else if (rd_slot_valid) begin
                mod_word[RANK_LSB +: RANK_W] = rd_rank + RANK_W'(1);
            end
        end else if (func_reg == FUNC_CHANGE) begin
            if (proc_idx == hit_idx_reg) begin
                mod_word[RANK_LSB +: RANK_W] = '0;
                mod_word[SIZE_LSB +: SIZE_W] = now_reg;
                mod_word[PEAK_LSB +: SIZE_W] = peak_reg;
            end else if (rd_slot_valid && (rd_rank < hit_rank_reg)) begin
                mod_word[RANK_LSB +: RANK_W] = rd_rank + RANK_W'(1);
            end
        end else if (func_reg == FUNC_DELETE) begin
            if (proc_idx == hit_idx_reg) begin
                mod_word[VALID_BIT] = 1'b0;
            end else if (rd_slot_valid && (rd_rank > hit_rank_reg)) begin
                mod_word[RANK_LSB +: RANK_W] = rd_rank - RANK_W'(1);
            end
        end
    end

    rret_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_slot_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(cnt_reg[IDX_W-1:0]),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (cnt_reg == CNT_W'(ENTRIES - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg       <= s_func;
                        addr_reg       <= s_region_address;
                        lim_reg        <= s_limit_size;
                        now_reg        <= s_now_size;
                        peak_reg       <= s_peak_size;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        res_prior_reg  <= '0;
                        cnt_reg        <= '0;
                        state_reg      <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (data_ok) begin
                        if (rd_slot_valid && (rd_addr == addr_reg)) begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= proc_idx;
                            hit_rank_reg <= rd_rank;
                        end
                        if (!rd_slot_valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= proc_idx;
                        end
                    end
                    if (sweep_end) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DECIDE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DECIDE: begin
                    if (func_reg == FUNC_INSERT) begin
                        if (hit_reg) begin
                            res_status_reg <= STATUS_DUP;
                            state_reg      <= ST_OUT;
                        end else if (count_reg == COUNT_REG_W'(ENTRIES)) begin
                            res_status_reg <= STATUS_FULL;
                            state_reg      <= ST_OUT;
                        end else begin
                            res_status_reg <= STATUS_OK;
                            state_reg      <= ST_MODIFY;
                        end
                    end else if ((func_reg == FUNC_CHANGE) || (func_reg == FUNC_DELETE)) begin
                        if (!hit_reg) begin
                            res_status_reg <= STATUS_MISS;
                            state_reg      <= ST_OUT;
                        end else begin
                            res_status_reg <= STATUS_OK;
                            res_prior_reg  <= hit_rank_reg;
                            state_reg      <= ST_MODIFY;
                        end
                    end else begin
                        res_status_reg <= STATUS_OK;
                        state_reg      <= ST_OUT;
                    end
                end
                ST_MODIFY: begin
                    if (sweep_end) begin
                        if (func_reg == FUNC_INSERT) begin
                            count_reg <= count_reg + COUNT_REG_W'(1);
                        end else if (func_reg == FUNC_DELETE) begin
                            count_reg <= count_reg - COUNT_REG_W'(1);
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= res_status_reg;
                        m_entry_count_reg <= COUNT_W'(count_reg);
                        m_prior_rank_reg  <= PRIOR_W'(res_prior_reg);
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_prior_rank  = m_prior_rank_reg;

    `RRET_ASSERT_NEXT(a_accept_starts_search, aclk, aresetn, s_valid && s_ready, (state_reg == ST_SEARCH) && (cnt_reg == '0), "transaction accepted but search not started")
    `RRET_ASSERT_IMPLIES(a_free_slot_found, aclk, aresetn, (state_reg == ST_DECIDE) && (func_reg == FUNC_INSERT) && !hit_reg && (count_reg != COUNT_REG_W'(ENTRIES)), free_found_reg, "insert with spare room but no free slot seen")
    `RRET_ASSERT_NEXT(a_insert_count, aclk, aresetn, (state_reg == ST_MODIFY) && sweep_end && (func_reg == FUNC_INSERT), count_reg == $past(count_reg) + COUNT_REG_W'(1), "entry count not raised by insert")

endmodule

// ===== src/rret_ram.sv =====
// ----------------------------------------------------------------------------
// rret_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rret_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
